// ===== sv/tgat_pkg.sv =====
// Shared types and codes for the two-generation aging table.
`timescale 1ns / 1ps
`default_nettype none
package tgat_pkg;

    localparam int TAG_W = 53;
    localparam int HDL_W = 16;
    localparam int LVL_W = 5;
    localparam int POS_W = 16;

    localparam logic [LVL_W-1:0] LVL_MAX = 5'd31;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_PRUNE  = 2'd2;
    localparam logic [1:0] OP_FLUSH  = 2'd3;

    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_ACK    = 2'd1;
    localparam logic [1:0] KIND_EVICT  = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;

    typedef logic [3:0] t_act;

    localparam t_act ACT_NONE    = 4'd0;
    localparam t_act ACT_LOOKUP  = 4'd1;
    localparam t_act ACT_DUP     = 4'd2;
    localparam t_act ACT_FULL    = 4'd3;
    localparam t_act ACT_INS_NEW = 4'd4;
    localparam t_act ACT_REPLACE = 4'd5;
    localparam t_act ACT_ACK     = 4'd6;
    localparam t_act ACT_PRUNE   = 4'd7;
    localparam t_act ACT_FLUSH   = 4'd8;
    localparam t_act ACT_EVICT   = 4'd9;
    localparam t_act ACT_AGE_LVL = 4'd10;
    localparam t_act ACT_DONE    = 4'd11;

    typedef struct packed {
        logic capture;
        t_act action;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       hit;
        logic       hit_aged;
        logic       full;
        logic       lvl_any;
        logic       evict_pend;
        logic       lvl_top;
        logic       out_free;
    } t_dp_stat;

    typedef struct packed {
        logic [1:0]       kind;
        logic             found;
        logic [1:0]       status;
        logic [LVL_W-1:0] lvl;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] z;
        logic [HDL_W-1:0] handle;
        logic             last;
    } t_res;

endpackage
`default_nettype wire

// ===== sv/tgat_in_if.sv =====
// Request channel of the aging table: one word is one table command.
`timescale 1ns / 1ps
`default_nettype none
interface tgat_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [4:0]  level;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [15:0] new_handle;

    modport source (output valid, opcode, level, pos_x, pos_y, pos_z, new_handle,
                    input ready);
    modport sink (input valid, opcode, level, pos_x, pos_y, pos_z, new_handle,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/tgat_out_if.sv =====
// Result channel of the aging table: one word is one result.
`timescale 1ns / 1ps
`default_nettype none
interface tgat_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        found;
    logic [1:0]  status;
    logic [4:0]  out_level;
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic [15:0] out_z;
    logic [15:0] handle;
    logic        last;

    modport source (output valid, kind, found, status, out_level, out_x, out_y, out_z,
                    handle, last, input ready);
    modport sink (input valid, kind, found, status, out_level, out_x, out_y, out_z,
                  handle, last, output ready);
endinterface
`default_nettype wire

// ===== sv/tgat_dp.sv =====
// Datapath of the aging table: entry store, tag match, prune walk and result register.
`timescale 1ns / 1ps
`default_nettype none
module tgat_dp #(
    parameter int ENTRIES = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tgat_pkg::t_dp_cmd  i_cmd,
    output tgat_pkg::t_dp_stat      o_stat,
    input  wire logic [1:0]         i_opcode,
    input  wire logic [4:0]         i_level,
    input  wire logic [15:0]        i_pos_x,
    input  wire logic [15:0]        i_pos_y,
    input  wire logic [15:0]        i_pos_z,
    input  wire logic [15:0]        i_new_handle,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output tgat_pkg::t_res          o_res
);
    localparam int SW = $clog2(ENTRIES);

    logic [tgat_pkg::TAG_W-1:0] r_tag [ENTRIES];
    logic [tgat_pkg::HDL_W-1:0] r_hdl [ENTRIES];
    logic [ENTRIES-1:0]         r_vld;
    logic [ENTRIES-1:0]         r_aged;
    logic [tgat_pkg::LVL_W-1:0] r_lvl;

    logic [1:0]                 r_op;
    logic [tgat_pkg::TAG_W-1:0] r_key;
    logic [tgat_pkg::HDL_W-1:0] r_nh;

    logic                       r_out_valid;
    tgat_pkg::t_res             r_res;
    tgat_pkg::t_res             n_res;
    logic                       emit;

    logic [ENTRIES-1:0] hit_vec;
    logic [ENTRIES-1:0] lvl_vec;
    logic [ENTRIES-1:0] ev_vec;
    logic [SW-1:0]      hit_idx;
    logic [SW-1:0]      free_idx;
    logic [SW-1:0]      ev_idx;
    logic               hit;

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        ev_idx   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i] = r_vld[i] && (r_tag[i] == r_key);
            lvl_vec[i] = r_vld[i] && (r_tag[i][tgat_pkg::TAG_W-1 -: tgat_pkg::LVL_W] == r_lvl);
            ev_vec[i]  = lvl_vec[i] && r_aged[i];
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_idx = SW'(i);
            end
            if (!r_vld[i]) begin
                free_idx = SW'(i);
            end
            if (ev_vec[i]) begin
                ev_idx = SW'(i);
            end
        end
    end

    assign hit = |hit_vec;

    always_comb begin
        o_stat.op         = r_op;
        o_stat.hit        = hit;
        o_stat.hit_aged   = r_aged[hit_idx];
        o_stat.full       = &r_vld;
        o_stat.lvl_any    = |lvl_vec;
        o_stat.evict_pend = |ev_vec;
        o_stat.lvl_top    = (r_lvl == tgat_pkg::LVL_MAX);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    always_comb begin
        n_res = '0;
        emit  = 1'b0;
        case (i_cmd.action) inside
            tgat_pkg::ACT_LOOKUP: begin
                emit         = 1'b1;
                n_res.kind   = tgat_pkg::KIND_LOOKUP;
                n_res.found  = hit;
                n_res.handle = hit ? r_hdl[hit_idx] : '0;
                n_res.last   = 1'b1;
            end
            tgat_pkg::ACT_DUP: begin
                emit         = 1'b1;
                n_res.kind   = tgat_pkg::KIND_ACK;
                n_res.status = tgat_pkg::ST_DUP;
                n_res.last   = 1'b1;
            end
            tgat_pkg::ACT_FULL: begin
                emit         = 1'b1;
                n_res.kind   = tgat_pkg::KIND_ACK;
                n_res.status = tgat_pkg::ST_FULL;
                n_res.last   = 1'b1;
            end
            tgat_pkg::ACT_INS_NEW, tgat_pkg::ACT_ACK: begin
                emit         = 1'b1;
                n_res.kind   = tgat_pkg::KIND_ACK;
                n_res.status = tgat_pkg::ST_OK;
                n_res.last   = 1'b1;
            end
            tgat_pkg::ACT_REPLACE: begin
                emit         = 1'b1;
                n_res.kind   = tgat_pkg::KIND_EVICT;
                {n_res.lvl, n_res.x, n_res.y, n_res.z} = r_tag[hit_idx];
                n_res.handle = r_hdl[hit_idx];
            end
            tgat_pkg::ACT_EVICT: begin
                emit         = 1'b1;
                n_res.kind   = tgat_pkg::KIND_EVICT;
                {n_res.lvl, n_res.x, n_res.y, n_res.z} = r_tag[ev_idx];
                n_res.handle = r_hdl[ev_idx];
            end
            tgat_pkg::ACT_DONE: begin
                emit         = 1'b1;
                n_res.kind   = tgat_pkg::KIND_DONE;
                n_res.last   = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_aged      <= '0;
            r_lvl       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.action)
                tgat_pkg::ACT_LOOKUP: begin
                    if (hit) begin
                        r_aged[hit_idx] <= 1'b0;
                    end
                end
                tgat_pkg::ACT_INS_NEW: begin
                    r_vld[free_idx]  <= 1'b1;
                    r_aged[free_idx] <= 1'b0;
                end
                tgat_pkg::ACT_REPLACE: begin
                    r_aged[hit_idx] <= 1'b0;
                end
                tgat_pkg::ACT_PRUNE: begin
                    r_lvl <= '0;
                end
                tgat_pkg::ACT_FLUSH: begin
                    r_aged <= r_aged | r_vld;
                    r_lvl  <= '0;
                end
                tgat_pkg::ACT_EVICT: begin
                    r_vld[ev_idx]  <= 1'b0;
                    r_aged[ev_idx] <= 1'b0;
                end
                tgat_pkg::ACT_AGE_LVL: begin
                    r_aged <= r_aged | lvl_vec;
                    r_lvl  <= r_lvl + 1'b1;
                end
                default: begin
                    r_lvl <= r_lvl;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_key <= {i_level, i_pos_x, i_pos_y, i_pos_z};
            r_nh  <= i_new_handle;
        end
        if (emit) begin
            r_res <= n_res;
        end
        if (i_cmd.action == tgat_pkg::ACT_INS_NEW) begin
            r_tag[free_idx] <= r_key;
            r_hdl[free_idx] <= r_nh;
        end else if (i_cmd.action == tgat_pkg::ACT_REPLACE) begin
            r_hdl[hit_idx] <= r_nh;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;
endmodule
`default_nettype wire

// ===== sv/tgat_ctrl.sv =====
// Controller of the aging table: sequences lookup, insert and the level-by-level prune walk.
`timescale 1ns / 1ps
`default_nettype none
module tgat_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire tgat_pkg::t_dp_stat i_stat,
    output tgat_pkg::t_dp_cmd       o_cmd
);
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_INS_ACK = 3'd2;
    localparam logic [2:0] S_P_CHECK = 3'd3;
    localparam logic [2:0] S_P_EVICT = 3'd4;
    localparam logic [2:0] S_P_AGE   = 3'd5;
    localparam logic [2:0] S_P_DONE  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.action = tgat_pkg::ACT_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_stat.op)
                    tgat_pkg::OP_LOOKUP: begin
                        if (i_stat.out_free) begin
                            o_cmd.action = tgat_pkg::ACT_LOOKUP;
                            n_state      = S_IDLE;
                        end
                    end
                    tgat_pkg::OP_INSERT: begin
                        if (i_stat.out_free) begin
                            if (i_stat.hit && !i_stat.hit_aged) begin
                                o_cmd.action = tgat_pkg::ACT_DUP;
                                n_state      = S_IDLE;
                            end else if (i_stat.hit) begin
                                o_cmd.action = tgat_pkg::ACT_REPLACE;
                                n_state      = S_INS_ACK;
                            end else if (i_stat.full) begin
                                o_cmd.action = tgat_pkg::ACT_FULL;
                                n_state      = S_IDLE;
                            end else begin
                                o_cmd.action = tgat_pkg::ACT_INS_NEW;
                                n_state      = S_IDLE;
                            end
                        end
                    end
                    tgat_pkg::OP_PRUNE: begin
                        o_cmd.action = tgat_pkg::ACT_PRUNE;
                        n_state      = S_P_CHECK;
                    end
                    default: begin
                        o_cmd.action = tgat_pkg::ACT_FLUSH;
                        n_state      = S_P_CHECK;
                    end
                endcase
            end
            S_INS_ACK: begin
                if (i_stat.out_free) begin
                    o_cmd.action = tgat_pkg::ACT_ACK;
                    n_state      = S_IDLE;
                end
            end
            S_P_CHECK: begin
                n_state = i_stat.lvl_any ? S_P_EVICT : S_P_DONE;
            end
            S_P_EVICT: begin
                if (!i_stat.evict_pend) begin
                    n_state = S_P_AGE;
                end else if (i_stat.out_free) begin
                    o_cmd.action = tgat_pkg::ACT_EVICT;
                end
            end
            S_P_AGE: begin
                o_cmd.action = tgat_pkg::ACT_AGE_LVL;
                n_state      = i_stat.lvl_top ? S_P_DONE : S_P_CHECK;
            end
            S_P_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.action = tgat_pkg::ACT_DONE;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

// ===== sv/two_generation_aging_table_top.sv =====
// Top level of the two-generation aging table: controller, datapath and channel wiring.
`timescale 1ns / 1ps
`default_nettype none
//  Channel   Direction  Word
//  i_in      sink       opcode, level, pos_x, pos_y, pos_z, new_handle
//  o_out     source     kind, found, status, out_level, out_x, out_y, out_z, handle, last
//
// A lookup or insert captures the word, then does one parallel tag match over all slots.
// An insert over an aged key gives a second result: the evict word, then the acknowledge.
// A prune walks the levels from zero, evicting the aged entries of a level, then aging it;
// it ends with the done word at the first level with no valid entry or after the top level.
// Reset is synchronous and clears all valid and aged marks; the table needs no clearing pass.
// A result waits in the output register while the next word is captured; a stalled
// output holds the controller in a state that emits a result until the register is free.
module two_generation_aging_table_top #(
    parameter int ENTRIES = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tgat_in_if.sink    i_in,
    tgat_out_if.source o_out
);
    tgat_pkg::t_dp_cmd  cmd;
    tgat_pkg::t_dp_stat stat;
    tgat_pkg::t_res     res;
    logic               out_valid;

    tgat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tgat_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_opcode     (i_in.opcode),
        .i_level      (i_in.level),
        .i_pos_x      (i_in.pos_x),
        .i_pos_y      (i_in.pos_y),
        .i_pos_z      (i_in.pos_z),
        .i_new_handle (i_in.new_handle),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (out_valid),
        .o_res        (res)
    );

    assign o_out.valid     = out_valid;
    assign o_out.kind      = res.kind;
    assign o_out.found     = res.found;
    assign o_out.status    = res.status;
    assign o_out.out_level = res.lvl;
    assign o_out.out_x     = res.x;
    assign o_out.out_y     = res.y;
    assign o_out.out_z     = res.z;
    assign o_out.handle    = res.handle;
    assign o_out.last      = res.last;
endmodule
`default_nettype wire
